// ===== sv/pnr_pkg.sv =====
`default_nettype none

package pnr_pkg;

    // fixed widths of the datapath
    localparam int FRAC_BITS  = 8;
    localparam int ACC_W      = 36;
    localparam int IDX_W      = 24;
    localparam int STEP_W     = 13;
    localparam int SAMPLE_W   = 16;
    localparam int MAX_OUT    = 16;
    localparam int BURST_W    = $clog2(MAX_OUT + 1);
    localparam int CFG_IDX_W  = 2;

    // reset values of the registers
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Q8      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_IS_16BIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_IS_16BIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT    = 2'd3;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // raw input bits to the output word format
    function automatic logic [SAMPLE_W-1:0] conv_sample(
        input logic [SAMPLE_W-1:0] raw,
        input logic                in16,
        input logic                out16
    );
        logic [SAMPLE_W-1:0] biased;
        logic [SAMPLE_W-1:0] s;
        biased = in16 ? (raw ^ 16'h8000) : {raw[7:0], 8'h00};
        s      = biased ^ 16'h8000;
        conv_sample = out16 ? s : {{8{s[15]}}, s[15:8]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/pcm_nearest_resampler.sv =====
`default_nettype none

// channel  dir  handshake             payload
// s_*      in   s_tvalid / s_tready   tdata: in_sample, tuser: start_req
// m_*      out  m_tvalid / m_tready   tdata: out_sample, tlast: last
// cfg_*    in   cfg_valid / cfg_ready cfg_index: register, cfg_data: value
//
// an input word with k output words (k at most 16) is taken in while idle; each
// output then goes through the single add/compare unit, and a closing step ends the
// burst and advances the source index; a stalled m_tready holds the outputs back.
// reset (rst_n low, asynchronous) clears the counters and the control registers.
// s_tready is high only between bursts; cfg writes are always taken.

module pcm_nearest_resampler (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pnr_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] in_sample
    input  wire logic                          s_tuser,   // [0] start_req
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pnr_pkg::SAMPLE_W-1:0]       m_tdata,   // [15:0] out_sample
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pnr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pnr_pkg::IDX_W-1:0]     cfg_data
);
    import pnr_pkg::*;

    state_t                state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  in16_reg, in16_next;
    logic                  out16_reg, out16_next;
    logic [IDX_W-1:0]      count_reg, count_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [IDX_W-1:0]      src_reg, src_next;
    logic [IDX_W-1:0]      dst_reg, dst_next;
    logic [BURST_W-1:0]    burst_reg, burst_next;
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic                  in_take;
    logic                  out_free;
    logic                  pending;
    logic                  emit;
    logic [IDX_W-1:0]      dst_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    assign in_take  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // shared unit: source index compare, count compare and accumulator add
    assign dst_inc = dst_reg + 1'b1;
    assign pending = (burst_reg < BURST_W'(MAX_OUT)) && (dst_reg < count_reg)
                  && (acc_reg[ACC_W-1:FRAC_BITS]
                      <= {{(ACC_W-FRAC_BITS-IDX_W){1'b0}}, src_reg});
    assign emit    = (state_reg == ST_RUN) && pending && out_free;

    // configuration writes
    always_comb
    begin
        step_next  = step_reg;
        in16_next  = in16_reg;
        out16_next = out16_reg;
        count_next = count_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STEP_Q8:      step_next  = cfg_data[STEP_W-1:0];
                CFG_IN_IS_16BIT:  in16_next  = cfg_data[0];
                CFG_OUT_IS_16BIT: out16_next = cfg_data[0];
                CFG_OUT_COUNT:    count_next = cfg_data;
            endcase
        end
    end

    // sequencer and counters
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        burst_next  = burst_reg;
        sample_next = sample_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    sample_next = conv_sample(s_tdata, in16_reg, out16_reg);
                    burst_next  = '0;
                    if (s_tuser)
                    begin
                        acc_next = '0;
                        src_next = '0;
                        dst_next = '0;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!pending)
                begin
                    src_next   = src_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else if (emit)
                begin
                    acc_next   = acc_reg + {{(ACC_W-STEP_W){1'b0}}, step_reg};
                    dst_next   = dst_inc;
                    burst_next = burst_reg + 1'b1;
                end
            end
        endcase
    end

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = sample_reg;
            m_tlast_next  = (dst_inc == count_reg);
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= STEP_RESET;
            in16_reg     <= 1'b0;
            out16_reg    <= 1'b0;
            count_reg    <= '0;
            acc_reg      <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            burst_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            in16_reg     <= in16_next;
            out16_reg    <= out16_next;
            count_reg    <= count_next;
            acc_reg      <= acc_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            burst_reg    <= burst_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

`ifndef SYNTH
    a_burst_limit: assert property (@(posedge clk) disable iff (!rst_n)
        burst_reg <= BURST_W'(MAX_OUT))
        else $error("burst count beyond limit");

    a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_tvalid_reg && (dst_reg == $past(dst_inc)))
        else $error("emitted word did not advance output index");

    a_take_starts_burst: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_RUN) && !s_tready && (burst_reg == '0))
        else $error("accepted word did not start a burst");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_pcm_nearest_resampler.sv =====
`timescale 1ns / 100ps

import pnr_pkg::*;

// tracks the resampler: registers, counters and the output words still due
class resampler_tracker;
    logic [STEP_W-1:0]   stride;
    bit                  wide_in;
    bit                  wide_out;
    logic [IDX_W-1:0]    total;
    logic [ACC_W-1:0]    pos_q8;
    logic [IDX_W-1:0]    src_num;
    logic [IDX_W-1:0]    dst_num;
    logic [SAMPLE_W-1:0] due_samples[$];
    bit                  due_last[$];
    int                  errors;

    function new();
        stride   = STEP_RESET;
        wide_in  = 1'b0;
        wide_out = 1'b0;
        total    = '0;
        pos_q8   = '0;
        src_num  = '0;
        dst_num  = '0;
        errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] value);
        case (idx)
            CFG_STEP_Q8:      stride   = value[STEP_W-1:0];
            CFG_IN_IS_16BIT:  wide_in  = value[0];
            CFG_OUT_IS_16BIT: wide_out = value[0];
            CFG_OUT_COUNT:    total    = value;
            default: ;
        endcase
    endfunction

    // one source word in, up to MAX_OUT output words whose source index it reaches out
    function void take_sample(bit start, logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0] signed16;
        logic [SAMPLE_W-1:0] word;
        int                  n;
        if (start)
        begin
            pos_q8  = '0;
            src_num = '0;
            dst_num = '0;
        end
        // 8-bit unsigned input is (x - 128) << 8
        signed16 = wide_in ? raw : {raw[7:0] ^ 8'h80, 8'h00};
        word     = wide_out ? signed16 : {{8{signed16[15]}}, signed16[15:8]};
        n = 0;
        while (n < MAX_OUT && dst_num < total && (pos_q8 >> FRAC_BITS) <= src_num)
        begin
            due_samples.push_back(word);
            due_last.push_back(dst_num + 1 == total);
            pos_q8  = pos_q8 + stride;
            dst_num = dst_num + 1'b1;
            n++;
        end
        src_num = src_num + 1'b1;
    endfunction

    function void check_word(logic [SAMPLE_W-1:0] got, bit got_last);
        logic [SAMPLE_W-1:0] want;
        bit                  want_last;
        if (due_samples.size() == 0)
        begin
            $display("%0t: unexpected output word, expected none, got %h last %b",
                     $time, got, got_last);
            errors++;
            return;
        end
        want      = due_samples.pop_front();
        want_last = due_last.pop_front();
        if (got !== want)
        begin
            $display("%0t: out_sample mismatch, expected %h, got %h", $time, want, got);
            errors++;
        end
        if (got_last !== want_last)
        begin
            $display("%0t: last mismatch, expected %b, got %b", $time, want_last, got_last);
            errors++;
        end
    endfunction

    function int due_count();
        return due_samples.size();
    endfunction
endclass

module tb_pcm_nearest_resampler;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 24;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata   = '0;   // [15:0] in_sample
    logic                 s_tuser   = 1'b0; // [0] start_req
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]  m_tdata;          // [15:0] out_sample
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [IDX_W-1:0]     cfg_data  = '0;

    resampler_tracker tracker = new();
    bit               calm = 1'b0;
    int               fed = 0;
    int               quiet_cycles = 0;

    pcm_nearest_resampler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // output words against the tracker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_word(m_tdata, m_tlast);
    end

    // watchdog on cycles without any word moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_pcm_nearest_resampler: errors");
            $finish;
        end
    end

    // output side stalls a random number of cycles before each word
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // valid stays high into the next word when there is no gap
    task automatic send_sample(input bit start, input logic [SAMPLE_W-1:0] raw);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= raw;
        do @(posedge clk); while (!s_tready);
        tracker.take_sample(start, raw);
        fed++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IDX_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(idx, value);
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
    endtask

    // drop valid, drain all due words, then let a trailing burst close
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.due_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_raw();
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'h0080;
            5:       return 16'h007F;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int               len;
        bit               resume;
        bit               start;
        logic [STEP_W-1:0] step;
        logic [IDX_W-1:0] count;
        longint           need;

        step = STEP_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: no outputs programmed
        send_sample(1'b1, 16'hFFFF);
        settle();

        // 8-bit in and out at 1:1, one word past the count
        write_reg(CFG_STEP_Q8, 24'd256);
        write_reg(CFG_IN_IS_16BIT, 24'd0);
        write_reg(CFG_OUT_IS_16BIT, 24'd0);
        write_reg(CFG_OUT_COUNT, 24'd6);
        cfg_release();
        send_sample(1'b1, 16'hAB00);
        send_sample(1'b0, 16'h00FF);
        send_sample(1'b0, 16'h5580);
        send_sample(1'b0, 16'hFF7F);
        send_sample(1'b0, 16'h0001);
        send_sample(1'b0, 16'hC3A5);
        send_sample(1'b0, 16'h8000);
        settle();

        // 16-bit in and out, full bursts of 16
        write_reg(CFG_STEP_Q8, 24'd16);
        write_reg(CFG_IN_IS_16BIT, 24'd1);
        write_reg(CFG_OUT_IS_16BIT, 24'd1);
        write_reg(CFG_OUT_COUNT, 24'd40);
        cfg_release();
        send_sample(1'b1, 16'h8000);
        send_sample(1'b0, 16'h7FFF);
        send_sample(1'b0, 16'h0000);
        settle();

        // zero step: burst limit carries outputs to the next word
        write_reg(CFG_STEP_Q8, 24'd0);
        write_reg(CFG_OUT_IS_16BIT, 24'd0);
        write_reg(CFG_OUT_COUNT, 24'd20);
        cfg_release();
        send_sample(1'b1, 16'h7FFF);
        send_sample(1'b0, 16'h8001);
        settle();

        // count lowered below outputs done, then raised to the maximum
        write_reg(CFG_STEP_Q8, 24'd128);
        write_reg(CFG_IN_IS_16BIT, 24'd0);
        write_reg(CFG_OUT_IS_16BIT, 24'd1);
        write_reg(CFG_OUT_COUNT, 24'd10);
        cfg_release();
        send_sample(1'b1, 16'h0080);
        send_sample(1'b0, 16'h007F);
        settle();
        write_reg(CFG_OUT_COUNT, 24'd2);
        cfg_release();
        send_sample(1'b0, 16'h00FF);
        settle();
        write_reg(CFG_OUT_COUNT, 24'hFFFFFF);
        cfg_release();
        send_sample(1'b0, 16'h0000);
        settle();

        // random sounds, mostly started cleanly, some resumed or restarted
        while (fed < 215)
        begin
            calm   = ($urandom_range(0, 3) == 0);
            resume = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0:       count = '0;
                1:       count = IDX_W'($urandom_range(0, 24'hFFFFFF));
                2:       count = 24'hFFFFFF;
                default: count = IDX_W'($urandom_range(1, 48));
            endcase
            if (!resume)
            begin
                case ($urandom_range(0, 9))
                    0:       step = STEP_W'($urandom_range(0, 15));
                    1:       step = 13'd16;
                    2:       step = 13'd4096;
                    3:       step = 13'd8191;
                    4:       step = STEP_W'($urandom_range(4097, 8191));
                    5:       step = 13'd128;
                    6:       step = 13'd512;
                    default: step = STEP_W'($urandom_range(16, 4096));
                endcase
                write_reg(CFG_STEP_Q8, IDX_W'(step));
                write_reg(CFG_IN_IS_16BIT, IDX_W'($urandom_range(0, 1)));
                write_reg(CFG_OUT_IS_16BIT, IDX_W'($urandom_range(0, 1)));
            end
            write_reg(CFG_OUT_COUNT, count);
            cfg_release();

            // enough words to finish short sounds, capped for slow steps
            if (count == 0 || count > 64)
                len = $urandom_range(3, 20);
            else
            begin
                need = (longint'(count - 1) * step) / 256 + 1;
                if (need < (count + 15) / 16)
                    need = (count + 15) / 16;
                need = need + $urandom_range(0, 2);
                len  = (need > 40) ? 40 : int'(need);
            end

            for (int i = 0; i < len; i++)
            begin
                start = (!resume && i == 0) || ($urandom_range(0, 15) == 0);
                send_sample(start, pick_raw());
            end
            settle();
        end

        if (tracker.errors == 0 && tracker.due_count() == 0)
            $display("tb_pcm_nearest_resampler: clean");
        else
            $display("tb_pcm_nearest_resampler: errors");
        $finish;
    end

endmodule
